// ===== design/mvsn_pkg.sv =====
package mvsn_pkg;

  // Voice count and sample memory geometry.
  localparam int VOICES       = 8;
  localparam int VW           = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW           = 4;
  localparam int SAMPLE_DEPTH = 32768;
  localparam int AW           = $clog2(SAMPLE_DEPTH);

  // Fixed constants of the voice arithmetic.
  localparam logic [31:0] SEED_STEP  = 32'h9E37_79B9;
  localparam logic [23:0] ENV_FLOOR  = 24'd15099;
  localparam logic [14:0] OUT_SCALE  = 15'd30000;
  localparam logic [31:0] SEED_RESET = 32'h0123_4567;

  // Item kinds.
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_NOISE  = 2'd2;
  localparam logic [1:0] KIND_WRITE  = 2'd3;

  // Configuration register indexes.
  localparam int          CFG_IW          = 3;
  localparam logic [2:0]  CFG_MASTER_GAIN = 3'd0;
  localparam logic [2:0]  CFG_NOISE_LEVEL = 3'd1;
  localparam logic [2:0]  CFG_NOISE_DECAY = 3'd2;
  localparam logic [2:0]  CFG_LOWPASS     = 3'd3;
  localparam logic [2:0]  CFG_BP_B0       = 3'd4;
  localparam logic [2:0]  CFG_BP_A1       = 3'd5;
  localparam logic [2:0]  CFG_BP_A2       = 3'd6;

  // Configuration reset values.
  localparam logic [14:0] RST_MASTER_GAIN = 15'd22938;
  localparam logic [14:0] RST_NOISE_LEVEL = 15'd26214;
  localparam logic [23:0] RST_NOISE_DECAY = 24'd16764533;
  localparam logic [15:0] RST_LOWPASS     = 16'd32768;
  localparam logic [23:0] RST_BP_B0       = 24'd19560;
  localparam logic [23:0] RST_BP_A1       = 24'h85_BB60;
  localparam logic [23:0] RST_BP_A2       = 24'd4155175;

  // Datapath operation codes issued by the controller.
  localparam logic [4:0] OP_IDLE  = 5'd0;
  localparam logic [4:0] OP_LATCH = 5'd1;
  localparam logic [4:0] OP_MEMWR = 5'd2;
  localparam logic [4:0] OP_PICK  = 5'd3;
  localparam logic [4:0] OP_START = 5'd4;
  localparam logic [4:0] OP_VCHK  = 5'd5;
  localparam logic [4:0] OP_SA    = 5'd6;
  localparam logic [4:0] OP_SB    = 5'd7;
  localparam logic [4:0] OP_SM1   = 5'd8;
  localparam logic [4:0] OP_SM2   = 5'd9;
  localparam logic [4:0] OP_SACC  = 5'd10;
  localparam logic [4:0] OP_N1    = 5'd11;
  localparam logic [4:0] OP_N2    = 5'd12;
  localparam logic [4:0] OP_N3    = 5'd13;
  localparam logic [4:0] OP_N4    = 5'd14;
  localparam logic [4:0] OP_N5    = 5'd15;
  localparam logic [4:0] OP_N6    = 5'd16;
  localparam logic [4:0] OP_NEXT  = 5'd17;
  localparam logic [4:0] OP_F1    = 5'd18;
  localparam logic [4:0] OP_F2    = 5'd19;
  localparam logic [4:0] OP_OUTLD = 5'd20;

  typedef struct packed {
    logic [4:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic active;
    logic is_sample;
    logic clip_end;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== design/mvsn_in_if.sv =====
interface mvsn_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [14:0]        sample_addr;
  logic [15:0]        sample_length;
  logic [15:0]        voice_gain;
  logic [16:0]        step_rate;
  logic signed [15:0] sample_data;

  modport source (output valid, kind, sample_addr, sample_length, voice_gain, step_rate,
                  sample_data, input ready);
  modport sink (input valid, kind, sample_addr, sample_length, voice_gain, step_rate,
                sample_data, output ready);
endinterface

// ===== design/mvsn_out_if.sv =====
interface mvsn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_out;
  logic [3:0]         active_voices;

  modport source (output valid, pcm_out, active_voices, input ready);
  modport sink (input valid, pcm_out, active_voices, output ready);
endinterface

// ===== design/mvsn_cfg_if.sv =====
interface mvsn_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [23:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== design/mvsn_ctrl.sv =====
module mvsn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_kind,
  output logic               in_ready,
  output mvsn_pkg::dp_cmd_t  cmd,
  input  mvsn_pkg::dp_stat_t stat
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_WR    = 5'd1;
  localparam logic [4:0] S_PICK  = 5'd2;
  localparam logic [4:0] S_START = 5'd3;
  localparam logic [4:0] S_VCHK  = 5'd4;
  localparam logic [4:0] S_SA    = 5'd5;
  localparam logic [4:0] S_SB    = 5'd6;
  localparam logic [4:0] S_SM1   = 5'd7;
  localparam logic [4:0] S_SM2   = 5'd8;
  localparam logic [4:0] S_SACC  = 5'd9;
  localparam logic [4:0] S_N1    = 5'd10;
  localparam logic [4:0] S_N2    = 5'd11;
  localparam logic [4:0] S_N3    = 5'd12;
  localparam logic [4:0] S_N4    = 5'd13;
  localparam logic [4:0] S_N5    = 5'd14;
  localparam logic [4:0] S_N6    = 5'd15;
  localparam logic [4:0] S_NEXT  = 5'd16;
  localparam logic [4:0] S_F1    = 5'd17;
  localparam logic [4:0] S_F2    = 5'd18;
  localparam logic [4:0] S_F3    = 5'd19;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = mvsn_pkg::OP_IDLE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = mvsn_pkg::OP_LATCH;
          case (in_kind)
            mvsn_pkg::KIND_WRITE: state_next = S_WR;
            mvsn_pkg::KIND_TICK:  state_next = S_VCHK;
            default:              state_next = S_PICK;
          endcase
        end
      end
      S_WR: begin
        cmd.op     = mvsn_pkg::OP_MEMWR;
        state_next = S_IDLE;
      end
      S_PICK: begin
        cmd.op = mvsn_pkg::OP_PICK;
        if (stat.last) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.op     = mvsn_pkg::OP_START;
        state_next = S_IDLE;
      end
      S_VCHK: begin
        cmd.op = mvsn_pkg::OP_VCHK;
        if (!stat.active) begin
          state_next = S_NEXT;
        end else if (stat.is_sample) begin
          state_next = stat.clip_end ? S_NEXT : S_SA;
        end else begin
          state_next = S_N1;
        end
      end
      S_SA: begin
        cmd.op     = mvsn_pkg::OP_SA;
        state_next = S_SB;
      end
      S_SB: begin
        cmd.op     = mvsn_pkg::OP_SB;
        state_next = S_SM1;
      end
      S_SM1: begin
        cmd.op     = mvsn_pkg::OP_SM1;
        state_next = S_SM2;
      end
      S_SM2: begin
        cmd.op     = mvsn_pkg::OP_SM2;
        state_next = S_SACC;
      end
      S_SACC: begin
        cmd.op     = mvsn_pkg::OP_SACC;
        state_next = S_NEXT;
      end
      S_N1: begin
        cmd.op     = mvsn_pkg::OP_N1;
        state_next = S_N2;
      end
      S_N2: begin
        cmd.op     = mvsn_pkg::OP_N2;
        state_next = S_N3;
      end
      S_N3: begin
        cmd.op     = mvsn_pkg::OP_N3;
        state_next = S_N4;
      end
      S_N4: begin
        cmd.op     = mvsn_pkg::OP_N4;
        state_next = S_N5;
      end
      S_N5: begin
        cmd.op     = mvsn_pkg::OP_N5;
        state_next = S_N6;
      end
      S_N6: begin
        cmd.op     = mvsn_pkg::OP_N6;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        cmd.op     = mvsn_pkg::OP_NEXT;
        state_next = stat.last ? S_F1 : S_VCHK;
      end
      S_F1: begin
        cmd.op     = mvsn_pkg::OP_F1;
        state_next = S_F2;
      end
      S_F2: begin
        cmd.op     = mvsn_pkg::OP_F2;
        state_next = S_F3;
      end
      S_F3: begin
        // Wait for the output register to free up.
        if (!stat.out_busy) begin
          cmd.op     = mvsn_pkg::OP_OUTLD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/mvsn_dp.sv =====
module mvsn_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  mvsn_pkg::dp_cmd_t                  cmd,
  output mvsn_pkg::dp_stat_t                 stat,
  input  logic [1:0]                         in_kind,
  input  logic [14:0]                        in_sample_addr,
  input  logic [15:0]                        in_sample_length,
  input  logic [15:0]                        in_voice_gain,
  input  logic [16:0]                        in_step_rate,
  input  logic signed [15:0]                 in_sample_data,
  input  logic                               cfg_valid,
  input  logic [mvsn_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [23:0]                        cfg_wdata,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [15:0]                 out_pcm,
  output logic [mvsn_pkg::CW-1:0]            out_count
);

  localparam int VOICES = mvsn_pkg::VOICES;
  localparam int VW     = mvsn_pkg::VW;
  localparam int AW     = mvsn_pkg::AW;

  function automatic logic [31:0] xorshift32(input logic [31:0] r);
    logic [31:0] t;
    t = r ^ (r << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'sd8388607) begin
      r = 24'sh7F_FFFF;
    end else if (v < -28'sd8388608) begin
      r = 24'sh80_0000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [14:0]        master_gain;
  logic [14:0]        noise_level;
  logic [23:0]        noise_decay;
  logic [15:0]        lowpass_coef;
  logic signed [23:0] bp_b0;
  logic signed [23:0] bp_a1;
  logic signed [23:0] bp_a2;

  // Per-voice state.
  logic               act       [VOICES];
  logic               is_samp   [VOICES];
  logic [14:0]        clip_start[VOICES];
  logic [15:0]        clip_len  [VOICES];
  logic [31:0]        play_pos  [VOICES];
  logic [16:0]        play_step [VOICES];
  logic [15:0]        play_gain [VOICES];
  logic [31:0]        rng       [VOICES];
  logic signed [23:0] lp        [VOICES];
  logic signed [31:0] z1        [VOICES];
  logic signed [31:0] z2        [VOICES];
  logic [23:0]        env       [VOICES];
  logic [31:0]        noise_seed;

  // Sample memory.
  logic signed [15:0] mem [mvsn_pkg::SAMPLE_DEPTH];
  logic signed [15:0] rdata;
  logic [AW-1:0]      raddr;

  // Latched item and scan registers.
  logic [1:0]         kind_r;
  logic [14:0]        addr_r;
  logic [15:0]        len_r;
  logic [15:0]        gain_r;
  logic [16:0]        step_r;
  logic signed [15:0] data_r;
  logic [VW-1:0]      vidx;
  logic [VW-1:0]      best;
  logic               found;
  logic [23:0]        low;

  // Pipeline registers.
  logic signed [47:0]         acc;
  logic [mvsn_pkg::CW-1:0]    count;
  logic signed [15:0]         a_r;
  logic signed [33:0]         ps1;
  logic signed [35:0]         ps2;
  logic signed [41:0]         pn1;
  logic [47:0]                penv;
  logic signed [48:0]         pn2;
  logic signed [48:0]         pn3;
  logic signed [31:0]         y_r;
  logic signed [26:0]         bx_r;
  logic signed [55:0]         pa1;
  logic signed [55:0]         pa2;
  logic signed [43:0]         pt;
  logic signed [63:0]         pm;
  logic                       neg_r;
  logic [44:0]                pout;

  // Combinational terms.
  logic [31:0]        cur_pos;
  logic [15:0]        idx;
  logic               clip_end;
  logic [16:0]        sum_a;
  logic [16:0]        sum_b;
  logic [31:0]        rng_x;
  logic signed [22:0] white;
  logic signed [24:0] diff;
  logic signed [23:0] lp_new;
  logic signed [24:0] x;
  logic signed [26:0] bx;
  logic signed [31:0] y_new;
  logic signed [31:0] z1_new;
  logic signed [31:0] z2_new;
  logic [23:0]        env_new;
  logic signed [16:0] d;
  logic signed [18:0] s_new;
  logic signed [48:0] am;
  logic signed [30:0] clamped;
  logic [29:0]        mag;
  logic [15:0]        pcm_mag;
  logic [31:0]        seed_next;

  always_comb begin
    cur_pos  = play_pos[vidx];
    idx      = cur_pos[31:16];
    clip_end = ({1'b0, idx} + 17'd1) >= {1'b0, clip_len[vidx]};
    sum_a    = {2'b00, clip_start[vidx]} + {1'b0, idx};
    sum_b    = sum_a + 17'd1;
    raddr    = (cmd.op == mvsn_pkg::OP_SB) ? sum_b[AW-1:0] : sum_a[AW-1:0];

    rng_x   = xorshift32(rng[vidx]);
    white   = $signed({~rng_x[15], rng_x[14:0], 7'd0});
    diff    = 25'(white) - 25'(lp[vidx]);
    lp_new  = sat24(28'(lp[vidx]) + 28'($signed(pn1[41:15])));
    x       = $signed(pn2[48:24]);
    bx      = $signed(pn3[48:22]);
    y_new   = sat32(36'(bx) + 36'(z1[vidx]));
    z1_new  = sat32(36'(z2[vidx]) - 36'($signed(pa1[55:22])));
    z2_new  = sat32(-36'(bx_r) - 36'($signed(pa2[55:22])));
    env_new = penv[47:24];

    d     = 17'(rdata) - 17'(a_r);
    s_new = 19'(a_r) + 19'($signed(ps1[33:16]));

    am = $signed(pm[63:15]);
    if (am > 49'sd536870912) begin
      clamped = 31'sd536870912;
    end else if (am < -49'sd536870912) begin
      clamped = -31'sd536870912;
    end else begin
      clamped = am[30:0];
    end
    mag       = clamped[30] ? 30'(-clamped) : clamped[29:0];
    pcm_mag   = pout[44:29];
    seed_next = noise_seed + mvsn_pkg::SEED_STEP;
  end

  always_comb begin
    stat.last      = (vidx == VW'(VOICES - 1));
    stat.active    = act[vidx];
    stat.is_sample = is_samp[vidx];
    stat.clip_end  = clip_end;
    stat.out_busy  = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_gain  <= mvsn_pkg::RST_MASTER_GAIN;
      noise_level  <= mvsn_pkg::RST_NOISE_LEVEL;
      noise_decay  <= mvsn_pkg::RST_NOISE_DECAY;
      lowpass_coef <= mvsn_pkg::RST_LOWPASS;
      bp_b0        <= mvsn_pkg::RST_BP_B0;
      bp_a1        <= mvsn_pkg::RST_BP_A1;
      bp_a2        <= mvsn_pkg::RST_BP_A2;
    end else if (cfg_valid) begin
      case (cfg_index)
        mvsn_pkg::CFG_MASTER_GAIN: master_gain  <= cfg_wdata[14:0];
        mvsn_pkg::CFG_NOISE_LEVEL: noise_level  <= cfg_wdata[14:0];
        mvsn_pkg::CFG_NOISE_DECAY: noise_decay  <= cfg_wdata;
        mvsn_pkg::CFG_LOWPASS:     lowpass_coef <= cfg_wdata[15:0];
        mvsn_pkg::CFG_BP_B0:       bp_b0        <= cfg_wdata;
        mvsn_pkg::CFG_BP_A1:       bp_a1        <= cfg_wdata;
        mvsn_pkg::CFG_BP_A2:       bp_a2        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mvsn_pkg::OP_MEMWR) begin
      mem[addr_r[AW-1:0]] <= data_r;
    end
    rdata <= mem[raddr];
  end

  // Control state: voice activity, seed and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        act[i] <= 1'b0;
      end
      noise_seed <= mvsn_pkg::SEED_RESET;
      out_valid  <= 1'b0;
    end else begin
      case (cmd.op)
        mvsn_pkg::OP_START: begin
          act[best] <= 1'b1;
          if (kind_r == mvsn_pkg::KIND_NOISE) begin
            noise_seed <= seed_next;
          end
        end
        mvsn_pkg::OP_VCHK: begin
          if (is_samp[vidx] && clip_end) begin
            act[vidx] <= 1'b0;
          end
        end
        mvsn_pkg::OP_N6: begin
          if (env_new < mvsn_pkg::ENV_FLOOR) begin
            act[vidx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (cmd.op == mvsn_pkg::OP_OUTLD) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mvsn_pkg::OP_LATCH: begin
        kind_r <= in_kind;
        addr_r <= in_sample_addr;
        len_r  <= in_sample_length;
        gain_r <= in_voice_gain;
        step_r <= in_step_rate;
        data_r <= in_sample_data;
        vidx   <= '0;
        best   <= '0;
        found  <= 1'b0;
        low    <= '1;
        acc    <= '0;
        count  <= '0;
      end
      mvsn_pkg::OP_PICK: begin
        if (!found) begin
          if (!act[vidx]) begin
            best  <= vidx;
            found <= 1'b1;
          end else if (env[vidx] < low) begin
            best <= vidx;
            low  <= env[vidx];
          end
        end
        vidx <= vidx + VW'(1);
      end
      mvsn_pkg::OP_START: begin
        play_pos[best] <= '0;
        lp[best]       <= '0;
        z1[best]       <= '0;
        z2[best]       <= '0;
        if (kind_r == mvsn_pkg::KIND_SAMPLE) begin
          is_samp[best]    <= 1'b1;
          clip_start[best] <= addr_r;
          clip_len[best]   <= len_r;
          play_step[best]  <= step_r;
          play_gain[best]  <= gain_r;
          rng[best]        <= '0;
          env[best]        <= '0;
        end else begin
          is_samp[best]    <= 1'b0;
          clip_start[best] <= '0;
          clip_len[best]   <= '0;
          play_step[best]  <= '0;
          play_gain[best]  <= '0;
          rng[best]        <= seed_next | 32'd1;
          env[best]        <= {noise_level, 9'd0};
        end
      end
      mvsn_pkg::OP_SB: begin
        a_r <= rdata;
      end
      mvsn_pkg::OP_SM1: begin
        ps1 <= d * $signed({1'b0, cur_pos[15:0]});
      end
      mvsn_pkg::OP_SM2: begin
        ps2            <= s_new * $signed({1'b0, play_gain[vidx]});
        play_pos[vidx] <= cur_pos + 32'(play_step[vidx]);
      end
      mvsn_pkg::OP_SACC: begin
        acc   <= acc + 48'(ps2);
        count <= count + mvsn_pkg::CW'(1);
      end
      mvsn_pkg::OP_N1: begin
        rng[vidx] <= rng_x;
        pn1       <= diff * $signed({1'b0, lowpass_coef});
        penv      <= 48'(env[vidx]) * 48'(noise_decay);
      end
      mvsn_pkg::OP_N2: begin
        lp[vidx] <= lp_new;
        pn2      <= lp_new * $signed({1'b0, env[vidx]});
      end
      mvsn_pkg::OP_N3: begin
        pn3 <= bp_b0 * x;
      end
      mvsn_pkg::OP_N4: begin
        y_r  <= y_new;
        bx_r <= bx;
      end
      mvsn_pkg::OP_N5: begin
        pa1 <= bp_a1 * y_r;
        pa2 <= bp_a2 * y_r;
        pt  <= y_r * $signed(12'sd1229);
      end
      mvsn_pkg::OP_N6: begin
        z1[vidx]  <= z1_new;
        z2[vidx]  <= z2_new;
        env[vidx] <= env_new;
        acc       <= acc + 48'($signed(pt[43:3]));
        if (env_new >= mvsn_pkg::ENV_FLOOR) begin
          count <= count + mvsn_pkg::CW'(1);
        end
      end
      mvsn_pkg::OP_NEXT: begin
        vidx <= vidx + VW'(1);
      end
      mvsn_pkg::OP_F1: begin
        pm <= acc * $signed({1'b0, master_gain});
      end
      mvsn_pkg::OP_F2: begin
        neg_r <= clamped[30];
        pout  <= 45'(mag) * 45'(mvsn_pkg::OUT_SCALE);
      end
      mvsn_pkg::OP_OUTLD: begin
        out_pcm   <= neg_r ? $signed(-pcm_mag) : $signed(pcm_mag);
        out_count <= count;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/multi_voice_sample_noise_mixer_core.sv =====
// Eight-voice sample and noise mixer. Each input transaction is one of four kinds: a
// sample memory write, a sample voice start, a noise voice start, or a tick that renders
// one output sample; only a tick produces an output transaction, carrying the clamped
// pcm_out (scaled to +-30000) and the count of voices still sounding. Items are handled
// one at a time by a controller that steps a shared datapath through the voices. A write
// stores one memory word, a voice start runs a steal search that visits each voice
// once, and a tick visits every voice in turn, skipping idle or ended ones, and then
// scales the mix. Sample voices need two reads on the single sample memory read port for
// the interpolation pair; noise voices run a six-step chain through the low-pass, the
// band-pass biquad and the envelope multiply. A finished result sits in an output
// register, so the next transaction is accepted while it waits; a tick that completes
// before the previous result was taken holds until it is. Configuration is always
// ready and must only be written while idle.
module multi_voice_sample_noise_mixer_core (
  input  logic         clk,
  input  logic         rst,
  mvsn_in_if.sink      sample_in,
  mvsn_out_if.source   mix_out,
  mvsn_cfg_if.sink     cfg
);

  mvsn_pkg::dp_cmd_t  cmd;
  mvsn_pkg::dp_stat_t stat;

  // Register writes complete in the cycle they are offered.
  assign cfg.ready = 1'b1;

  // The controller sequences the items; the datapath holds all voice state.
  mvsn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_kind  (sample_in.kind),
    .in_ready (sample_in.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  mvsn_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (sample_in.kind),
    .in_sample_addr   (sample_in.sample_addr),
    .in_sample_length (sample_in.sample_length),
    .in_voice_gain    (sample_in.voice_gain),
    .in_step_rate     (sample_in.step_rate),
    .in_sample_data   (sample_in.sample_data),
    .cfg_valid        (cfg.valid),
    .cfg_index        (cfg.reg_index),
    .cfg_wdata        (cfg.wdata),
    .out_ready        (mix_out.ready),
    .out_valid        (mix_out.valid),
    .out_pcm          (mix_out.pcm_out),
    .out_count        (mix_out.active_voices)
  );

`ifndef NO_ASSERTIONS
  // The voice count can never exceed the number of voices.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    mix_out.valid |-> (mix_out.active_voices <= 4'(mvsn_pkg::VOICES)))
    else $error("active voice count out of range");

  // The output scaling keeps every sample within +-30000.
  a_pcm_range: assert property (@(posedge clk) disable iff (rst)
    mix_out.valid |-> ((mix_out.pcm_out <= 16'sd30000) && (mix_out.pcm_out >= -16'sd30000)))
    else $error("pcm sample out of range");

  // A result never appears in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (sample_in.valid && sample_in.ready) |=> !$rose(mix_out.valid))
    else $error("result raised directly after acceptance");

  // The controller takes no new item while it is stepping through voices.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != mvsn_pkg::OP_IDLE && cmd.op != mvsn_pkg::OP_LATCH) |-> !sample_in.ready)
    else $error("input ready while busy");
`endif

endmodule
